// ----- hw/rtl/ipv4_lpm_pkg.sv -----
// Shared types and constants for the IPv4 forwarding and route lookup block.
package ipv4_lpm_pkg;

   // Default size of the route table.
   localparam int ROUTE_ENTRIES_DEFAULT = 64;

   // Longest prefix that a route can carry.
   localparam logic [5:0] PREFIX_LEN_MAX = 6'd32;

   // Request commands.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_WORD  = 2'd2;

   // Verdict codes.
   localparam logic [1:0] ACT_LOCAL    = 2'd0;
   localparam logic [1:0] ACT_FORWARD  = 2'd1;
   localparam logic [1:0] ACT_TTL_DROP = 2'd2;
   localparam logic [1:0] ACT_NO_ROUTE = 2'd3;

   // Header word positions that the parser cares about.
   localparam logic [4:0] IDX_IHL    = 5'd0;
   localparam logic [4:0] IDX_TTL    = 5'd4;
   localparam logic [4:0] IDX_CSUM   = 5'd5;
   localparam logic [4:0] IDX_DST_HI = 5'd8;
   localparam logic [4:0] IDX_DST_LO = 5'd9;
   localparam logic [4:0] IDX_LIMIT  = 5'd31;

   // One request.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] route_prefix;
      logic [5:0]  prefix_len;
      logic [31:0] route_next_hop;
      logic [15:0] header_word;
      logic        last_word;
   } req_data_type;

   // One verdict.
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] next_hop;
      logic [7:0]  new_ttl;
      logic [15:0] new_checksum;
   } rsp_data_type;

   // One stored route as it sits in the table memory.
   typedef struct packed {
      logic [31:0] dest;
      logic [5:0]  len;
      logic [31:0] hop;
   } route_entry_type;

endpackage

// ----- hw/rtl/ipv4_forward_lpm_unit.sv -----
// IPv4 forwarding engine: header parser, route table and longest-prefix lookup.
//
// Requests arrive on req_valid/req_ready/req_data. Header words stream one per
// cycle, first word first; the word marked last ends the packet and yields one
// verdict on rsp_valid/rsp_ready. The local address is written through
// csr_wr_en/csr_wr_data, by the user only while idle; the block never checks.
//
// After the accepted last word the block passes the decide state, then the walk
// when the verdict needs a lookup (TTL nonzero, not local, table not empty),
// then the finish state. The lookup reads one table entry per cycle from the
// route memory's single read port, so a packet costs its header words plus that
// walk. Requests are not taken in the decide, walk and finish states.
//
// A verdict waits in the output register until taken; the next packet's words
// and route updates are accepted meanwhile. If the following verdict is ready
// before the receiver takes the previous one, the block holds and stops taking
// requests until rsp_ready frees the output register.
//
// Reset empties the route table (count to zero), clears the packet state and
// the local address, and drops any pending verdict.
module ipv4_forward_lpm_unit
   import ipv4_lpm_pkg::*;
#(
   parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   localparam int AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int CW = $clog2(ROUTE_ENTRIES + 1);
   localparam int EW = $bits(route_entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   route_count_ff, route_count_in;
   logic [4:0]      word_index_ff, word_index_in;
   logic [3:0]      hlw_ff, hlw_in;
   logic [7:0]      ttl_ff, ttl_in;
   logic [31:0]     dest_ff, dest_in;
   logic [20:0]     sum_ff, sum_in;
   logic [31:0]     local_ff, local_in;
   logic [31:0]     look_dest_ff, look_dest_in;
   logic [7:0]      new_ttl_ff, new_ttl_in;
   logic [15:0]     csum_ff, csum_in;
   logic [CW-1:0]   issue_ff, issue_in;
   logic            cmp_valid_ff, cmp_valid_in;
   logic [5:0]      best_len_ff, best_len_in;
   logic [31:0]     best_hop_ff, best_hop_in;
   logic [1:0]      verdict_ff, verdict_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_data_type    rsp_data_ff, rsp_data_in;

   logic            req_fire;
   logic            ram_wr_en;
   logic            ram_rd_en;
   route_entry_type ram_wr_entry;
   route_entry_type ram_rd_entry;
   logic [EW-1:0]   ram_rd_bits;
   logic [5:0]      add_len;
   logic [3:0]      hlw_upd;
   logic [15:0]     sum_add;
   logic            sum_take;
   logic [16:0]     fold_one;
   logic [16:0]     fold_two;
   logic [31:0]     entry_mask;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Route add: clamp the length and write the next free entry.
   assign add_len   = (req_data.prefix_len > PREFIX_LEN_MAX) ? PREFIX_LEN_MAX
                                                           : req_data.prefix_len;
   assign ram_wr_en = req_fire && (req_data.cmd == CMD_ADD) &&
                      (route_count_ff < CW'(ROUTE_ENTRIES));
   assign ram_wr_entry = '{dest: req_data.route_prefix, len: add_len,
                           hop: req_data.route_next_hop};

   // Table walk issues one read per cycle below the route count.
   assign ram_rd_en = (state_ff == ST_WALK) && (issue_ff < route_count_ff);

   ipv4_lpm_ram #(
      .WIDTH (EW),
      .DEPTH (ROUTE_ENTRIES)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (route_count_ff[AW-1:0]),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_entry = route_entry_type'(ram_rd_bits);

   // Mask of the entry under compare; length zero gives an empty mask.
   assign entry_mask = ~(32'hFFFF_FFFF >> ram_rd_entry.len);

   // Checksum contribution of the current header word.
   assign hlw_upd  = (word_index_ff == IDX_IHL) ? req_data.header_word[11:8] : hlw_ff;
   assign sum_take = (word_index_ff != IDX_LIMIT) && (word_index_ff < {hlw_upd, 1'b0});
   always_comb begin
      priority if (word_index_ff == IDX_TTL) begin
         sum_add = {req_data.header_word[15:8] - 8'd1, req_data.header_word[7:0]};
      end else if (word_index_ff == IDX_CSUM) begin
         sum_add = 16'd0;
      end else begin
         sum_add = req_data.header_word;
      end
   end

   // Two folds of the running sum.
   assign fold_one = {1'b0, sum_ff[15:0]} + {12'd0, sum_ff[20:16]};
   assign fold_two = {1'b0, fold_one[15:0]} + {16'd0, fold_one[16]};

   // Next-state logic.
   always_comb begin
      state_in       = state_ff;
      route_count_in = route_count_ff;
      word_index_in  = word_index_ff;
      hlw_in         = hlw_ff;
      ttl_in         = ttl_ff;
      dest_in        = dest_ff;
      sum_in         = sum_ff;
      local_in       = local_ff;
      look_dest_in   = look_dest_ff;
      new_ttl_in     = new_ttl_ff;
      csum_in        = csum_ff;
      issue_in       = issue_ff;
      cmp_valid_in   = 1'b0;
      best_len_in    = best_len_ff;
      best_hop_in    = best_hop_ff;
      verdict_in     = verdict_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      if (csr_wr_en) begin
         local_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.cmd)
                  CMD_CLEAR: begin
                     route_count_in = '0;
                  end
                  CMD_ADD: begin
                     if (ram_wr_en) begin
                        route_count_in = route_count_ff + CW'(1);
                     end
                  end
                  CMD_WORD: begin
                     hlw_in = hlw_upd;
                     if (word_index_ff == IDX_TTL) begin
                        ttl_in = req_data.header_word[15:8];
                     end
                     if (word_index_ff == IDX_DST_HI) begin
                        dest_in = {req_data.header_word, dest_ff[15:0]};
                     end
                     if (word_index_ff == IDX_DST_LO) begin
                        dest_in = {dest_ff[31:16], req_data.header_word};
                     end
                     if (sum_take) begin
                        sum_in = sum_ff + {5'd0, sum_add};
                     end
                     if (word_index_ff != IDX_LIMIT) begin
                        word_index_in = word_index_ff + 5'd1;
                     end
                     if (req_data.last_word) begin
                        state_in = ST_DECIDE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DECIDE: begin
            // Capture what the verdict needs, then free the packet state.
            look_dest_in  = dest_ff;
            new_ttl_in    = ttl_ff - 8'd1;
            csum_in       = ~fold_two[15:0];
            word_index_in = '0;
            hlw_in        = '0;
            ttl_in        = '0;
            dest_in       = '0;
            sum_in        = '0;
            priority if (ttl_ff == 8'd0) begin
               verdict_in = ACT_TTL_DROP;
               state_in   = ST_FINISH;
            end else if (dest_ff == local_ff) begin
               verdict_in = ACT_LOCAL;
               state_in   = ST_FINISH;
            end else if (route_count_ff == '0) begin
               verdict_in = ACT_NO_ROUTE;
               state_in   = ST_FINISH;
            end else begin
               issue_in    = '0;
               best_len_in = '0;
               best_hop_in = '0;
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            // Issue the next read; compare the entry read last cycle.
            if (ram_rd_en) begin
               issue_in     = issue_ff + CW'(1);
               cmp_valid_in = 1'b1;
            end
            if (cmp_valid_ff) begin
               if ((ram_rd_entry.len > best_len_ff) &&
                   ((look_dest_ff & entry_mask) == ram_rd_entry.dest)) begin
                  best_len_in = ram_rd_entry.len;
                  best_hop_in = ram_rd_entry.hop;
               end
            end else if (!ram_rd_en) begin
               verdict_in = (best_len_ff != '0) ? ACT_FORWARD : ACT_NO_ROUTE;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.action  = verdict_ff;
               if (verdict_ff == ACT_FORWARD) begin
                  rsp_data_in.next_hop     = best_hop_ff;
                  rsp_data_in.new_ttl      = new_ttl_ff;
                  rsp_data_in.new_checksum = csum_ff;
               end else begin
                  rsp_data_in.next_hop     = '0;
                  rsp_data_in.new_ttl      = '0;
                  rsp_data_in.new_checksum = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         route_count_ff <= '0;
         word_index_ff  <= '0;
         hlw_ff         <= '0;
         ttl_ff         <= '0;
         dest_ff        <= '0;
         sum_ff         <= '0;
         local_ff       <= '0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         route_count_ff <= route_count_in;
         word_index_ff  <= word_index_in;
         hlw_ff         <= hlw_in;
         ttl_ff         <= ttl_in;
         dest_ff        <= dest_in;
         sum_ff         <= sum_in;
         local_ff       <= local_in;
         cmp_valid_ff   <= cmp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      look_dest_ff <= look_dest_in;
      new_ttl_ff   <= new_ttl_in;
      csum_ff      <= csum_in;
      issue_ff     <= issue_in;
      best_len_ff  <= best_len_in;
      best_hop_ff  <= best_hop_in;
      verdict_ff   <= verdict_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef SYNTH
   // The route count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      route_count_ff <= CW'(ROUTE_ENTRIES))
      else $error("route count beyond table size");

   // A new verdict appears only out of the finishing state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("verdict raised outside finish");

   // The table is never written while a lookup is walking it.
   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_IDLE))
      else $error("route write during lookup");

   // The walk never reads past the filled part of the table.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (issue_ff <= route_count_ff))
      else $error("lookup index beyond route count");

   // A forwarded packet always had a nonzero TTL.
   a_fwd_ttl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.action == ACT_FORWARD)) |->
         (rsp_data_ff.new_ttl != 8'hFF))
      else $error("forward verdict with wrapped TTL");
`endif

endmodule

// ----- hw/rtl/ipv4_lpm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ipv4_lpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
